// ===== hw/rtl/zrle_pkg.sv =====
// Shared types and constants of the zero-run / literal-run encoder.
`timescale 1ns / 1ps

package zrle_pkg;

    localparam int MAX_RUN_DEF = 127;
    localparam int RUN_W       = 7;
    localparam int BYTE_W      = 8;
    localparam int WORD_BYTES  = 8;
    localparam int WORD_W      = WORD_BYTES * BYTE_W;
    localparam int CNT_W       = 4;
    localparam int LANE_W      = 3;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_data;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] packed_bytes;
        logic [CNT_W-1:0]  byte_count;
        logic              last_of_run;
    } t_out_item;

    typedef struct packed {
        logic              done;
        logic [BYTE_W-1:0] data;
    } t_sym;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_WRITE,
        ST_HEADER,
        ST_LITERAL,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        PH_HELD,
        PH_LAST,
        PH_FLUSH
    } t_phase;

endpackage

// ===== hw/rtl/zrle_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module zrle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 127,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/zrle_ctrl.sv =====
// Run sequencer: classifies bytes, stores literals, emits encoded bytes.
`timescale 1ns / 1ps

module zrle_ctrl import zrle_pkg::*; #(
    parameter int MAX_RUN = MAX_RUN_DEF,
    localparam int AW     = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_sym_valid,
    input  logic              i_sym_ready,
    output t_sym              o_sym,
    output logic              o_ram_we,
    output logic [AW-1:0]     o_ram_waddr,
    output logic [BYTE_W-1:0] o_ram_wdata,
    output logic              o_ram_re,
    output logic [AW-1:0]     o_ram_raddr,
    input  logic [BYTE_W-1:0] i_ram_rdata
);

    localparam logic [RUN_W-1:0] MAX_LEN = RUN_W'(MAX_RUN);

    t_state             r_state, n_state;
    t_phase             r_phase, n_phase;
    logic [BYTE_W-1:0]  r_held_byte, n_held_byte;
    logic               r_held_valid, n_held_valid;
    logic               r_in_zero, n_in_zero;
    logic [RUN_W-1:0]   r_run_len, n_run_len;
    logic               r_emitted, n_emitted;
    logic [BYTE_W-1:0]  r_cur, n_cur;
    logic               r_nxt_nz, n_nxt_nz;
    logic [BYTE_W-1:0]  r_in_byte, n_in_byte;
    logic               r_in_last, n_in_last;
    logic               r_new_zero, n_new_zero;
    logic [RUN_W-1:0]   r_idx, n_idx;

    logic               w_accept;
    logic               w_sym_fire;
    logic               w_zero;
    logic               w_close;
    logic               w_need_hdr;
    logic               w_do_write;
    logic [RUN_W-1:0]   w_idx_inc;
    logic               w_close_done;

    assign w_accept     = i_in_valid && o_in_ready;
    assign w_sym_fire   = o_sym_valid && i_sym_ready;
    assign w_zero       = (r_cur == '0) && (r_in_zero || !r_nxt_nz);
    assign w_close      = (w_zero != r_in_zero) || (r_run_len >= MAX_LEN);
    assign w_need_hdr   = w_close && !(r_in_zero && (r_run_len == '0));
    assign w_do_write   = (r_state == ST_WRITE) || ((r_state == ST_DECIDE) && !w_need_hdr);
    assign w_idx_inc    = r_idx + RUN_W'(1);
    assign w_close_done = w_sym_fire &&
                          (((r_state == ST_HEADER) && r_in_zero) ||
                           ((r_state == ST_LITERAL) && (w_idx_inc == r_run_len)));

    always_comb begin
        t_state write_next;
        t_state close_next;
        case (r_phase)
            PH_HELD: begin
                if (r_in_last) begin
                    write_next = ST_DECIDE;
                end else if (r_emitted) begin
                    write_next = ST_DONE;
                end else begin
                    write_next = ST_IDLE;
                end
            end
            PH_LAST: begin
                write_next = ST_HEADER;
            end
            default: begin
                write_next = ST_IDLE;
            end
        endcase
        close_next = (r_phase == PH_FLUSH) ? ST_DONE : ST_WRITE;
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (r_held_valid || i_in_data.end_of_data)) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_state = w_need_hdr ? ST_HEADER : write_next;
            end
            ST_WRITE: begin
                n_state = write_next;
            end
            ST_HEADER: begin
                if (w_sym_fire) begin
                    n_state = r_in_zero ? close_next : ST_LITERAL;
                end
            end
            ST_LITERAL: begin
                if (w_close_done) begin
                    n_state = close_next;
                end
            end
            ST_DONE: begin
                if (w_sym_fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready  = (r_state == ST_IDLE);
        o_sym_valid = 1'b0;
        o_sym       = '0;
        o_ram_re    = 1'b0;
        o_ram_raddr = '0;
        case (r_state)
            ST_HEADER: begin
                o_sym_valid = 1'b1;
                o_sym.data  = {r_in_zero, r_run_len};
                o_ram_re    = w_sym_fire && !r_in_zero;
            end
            ST_LITERAL: begin
                o_sym_valid = 1'b1;
                o_sym.data  = i_ram_rdata;
                o_ram_re    = w_sym_fire && !w_close_done;
                o_ram_raddr = w_idx_inc[AW-1:0];
            end
            ST_DONE: begin
                o_sym_valid = 1'b1;
                o_sym.done  = 1'b1;
            end
            default: begin
                o_sym_valid = 1'b0;
            end
        endcase
        o_ram_we    = w_do_write;
        o_ram_waddr = r_run_len[AW-1:0];
        o_ram_wdata = r_cur;
    end

    always_comb begin
        n_phase      = r_phase;
        n_held_byte  = r_held_byte;
        n_held_valid = r_held_valid;
        n_in_zero    = r_in_zero;
        n_run_len    = r_run_len;
        n_emitted    = r_emitted;
        n_cur        = r_cur;
        n_nxt_nz     = r_nxt_nz;
        n_in_byte    = r_in_byte;
        n_in_last    = r_in_last;
        n_new_zero   = r_new_zero;
        n_idx        = r_idx;

        if ((r_state == ST_IDLE) && w_accept) begin
            n_in_byte = i_in_data.data_byte;
            n_in_last = i_in_data.end_of_data;
            n_emitted = 1'b0;
            if (r_held_valid) begin
                n_cur    = r_held_byte;
                n_nxt_nz = (i_in_data.data_byte != '0);
                n_phase  = PH_HELD;
            end else if (i_in_data.end_of_data) begin
                n_cur    = i_in_data.data_byte;
                n_nxt_nz = 1'b0;
                n_phase  = PH_LAST;
            end else begin
                n_held_byte  = i_in_data.data_byte;
                n_held_valid = 1'b1;
            end
        end

        if (r_state == ST_DECIDE) begin
            n_new_zero = w_zero;
            if (w_close && !w_need_hdr) begin
                n_in_zero = w_zero;
            end
        end

        if (w_sym_fire && !o_sym.done) begin
            n_emitted = 1'b1;
        end

        if ((r_state == ST_HEADER) && w_sym_fire && !r_in_zero) begin
            n_idx = '0;
        end
        if ((r_state == ST_LITERAL) && w_sym_fire && !w_close_done) begin
            n_idx = w_idx_inc;
        end

        if (w_close_done) begin
            n_run_len = '0;
            if (r_phase == PH_FLUSH) begin
                n_held_byte  = '0;
                n_held_valid = 1'b0;
                n_in_zero    = 1'b1;
            end else begin
                n_in_zero = r_new_zero;
            end
        end

        if (w_do_write) begin
            n_run_len = r_run_len + RUN_W'(1);
            case (r_phase)
                PH_HELD: begin
                    if (r_in_last) begin
                        n_cur    = r_in_byte;
                        n_nxt_nz = 1'b0;
                        n_phase  = PH_LAST;
                    end else begin
                        n_held_byte  = r_in_byte;
                        n_held_valid = 1'b1;
                    end
                end
                PH_LAST: begin
                    n_phase = PH_FLUSH;
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_phase      <= PH_HELD;
            r_held_byte  <= '0;
            r_held_valid <= 1'b0;
            r_in_zero    <= 1'b1;
            r_run_len    <= '0;
            r_emitted    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_held_byte  <= n_held_byte;
            r_held_valid <= n_held_valid;
            r_in_zero    <= n_in_zero;
            r_run_len    <= n_run_len;
            r_emitted    <= n_emitted;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_nxt_nz   <= n_nxt_nz;
        r_in_byte  <= n_in_byte;
        r_in_last  <= n_in_last;
        r_new_zero <= n_new_zero;
        r_idx      <= n_idx;
    end

endmodule

// ===== hw/rtl/zrle_pack.sv =====
// Byte packer: gathers encoded bytes into words of up to eight bytes.
`timescale 1ns / 1ps

module zrle_pack import zrle_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_sym_valid,
    output logic      o_sym_ready,
    input  t_sym      i_sym,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic [WORD_W-1:0] r_acc, n_acc;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic w_need_push;
    logic w_out_free;
    logic w_fire;
    logic w_push;

    assign w_need_push = i_sym.done ? (r_cnt != '0) : (r_cnt == CNT_W'(WORD_BYTES));
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_sym_ready = !w_need_push || w_out_free;
    assign w_fire      = i_sym_valid && o_sym_ready;
    assign w_push      = w_fire && w_need_push;

    always_comb begin
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        if (w_push) begin
            n_out_valid              = 1'b1;
            n_out.packed_bytes       = r_acc;
            n_out.byte_count         = r_cnt;
            n_out.last_of_run        = i_sym.done;
        end
        if (w_fire) begin
            if (i_sym.done) begin
                n_acc = '0;
                n_cnt = '0;
            end else if (r_cnt == CNT_W'(WORD_BYTES)) begin
                n_acc = WORD_W'(i_sym.data);
                n_cnt = CNT_W'(1);
            end else begin
                n_acc[{r_cnt[LANE_W-1:0], 3'b000} +: BYTE_W] = i_sym.data;
                n_cnt = r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== hw/rtl/zero_run_literal_encoder.sv =====
// Top level of the zero-run / literal-run encoder.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------------
//  in      | input     | i_in_valid / o_in_ready | t_in_item: data_byte, end_of_data
//  out     | output    | o_out_valid/ i_out_ready| t_out_item: packed_bytes,
//          |           |                         |   byte_count, last_of_run
//
// One item at a time: the item is taken, then a decide step runs for each byte moved into a run
// (the held byte, and at stream end the last byte too). Closing a run emits each encoded byte
// (header plus literals read from the literal RAM) and, except for the final flush, then
// stores the byte after it; an item with output ends with a step that flushes the last word.
// Reset is synchronous; the literal RAM needs no clearing. A stalled output holds one word
// in the output register and, once a further word is due, stops the byte sequencer.
`timescale 1ns / 1ps

module zero_run_literal_encoder import zrle_pkg::*; #(
    parameter int MAX_RUN = MAX_RUN_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int AW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

    logic              w_sym_valid;
    logic              w_sym_ready;
    t_sym              w_sym;
    logic              w_ram_we;
    logic [AW-1:0]     w_ram_waddr;
    logic [BYTE_W-1:0] w_ram_wdata;
    logic              w_ram_re;
    logic [AW-1:0]     w_ram_raddr;
    logic [BYTE_W-1:0] w_ram_rdata;

    zrle_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_RUN)
    ) u_lit_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    zrle_ctrl #(
        .MAX_RUN (MAX_RUN)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_sym_valid (w_sym_valid),
        .i_sym_ready (w_sym_ready),
        .o_sym       (w_sym),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_re    (w_ram_re),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata)
    );

    zrle_pack u_pack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sym_valid (w_sym_valid),
        .o_sym_ready (w_sym_ready),
        .i_sym       (w_sym),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
